/* hw/rtl/lpcd_pkg.sv */
`timescale 1ns / 1ps
// lpcd_pkg: shared types and constants for the LRU priority cache directory.
// No dependencies.
package lpcd_pkg;

  localparam int ENTRIES_DEF  = 8;
  localparam int KEY_BITS_DEF = 64;
  localparam int IN_KEY_W     = 64;
  localparam int SLOT_W       = 3;
  localparam int PRIO_W       = 16;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } lpcd_state_t;

  typedef struct packed {
    logic rd_en;
    logic key_we;
    logic prio_we;
  } lpcd_mem_ctl_t;

endpackage

/* hw/rtl/lpcd_store.sv */
`timescale 1ns / 1ps
// lpcd_store: slot key and priority memories with registered reads, plus
// per-slot valid flags. Depends on lpcd_pkg.
module lpcd_store import lpcd_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX_W    = $clog2(ENTRIES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lpcd_mem_ctl_t             ctl,
  input  logic [IDX_W-1:0]          rd_addr,
  input  logic [IDX_W-1:0]          key_waddr,
  input  logic [KEY_BITS-1:0]       key_wdata,
  input  logic [IDX_W-1:0]          prio_waddr,
  input  logic signed [PRIO_W-1:0]  prio_wdata,
  output logic [KEY_BITS-1:0]       key_rdata,
  output logic signed [PRIO_W-1:0]  prio_rdata,
  output logic [ENTRIES-1:0]        valid
);

  logic [KEY_BITS-1:0]      key_mem  [ENTRIES];
  logic signed [PRIO_W-1:0] prio_mem [ENTRIES];
  logic [ENTRIES-1:0]       valid_r;

  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (ctl.rd_en) begin
      key_rdata <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prio_we) begin
      prio_mem[prio_waddr] <= prio_wdata;
    end
    if (ctl.rd_en) begin
      prio_rdata <= prio_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.key_we) begin
      valid_r[key_waddr] <= 1'b1;
    end
  end

  assign valid = valid_r;

endmodule

/* hw/rtl/lpcd_seq.sv */
`timescale 1ns / 1ps
// lpcd_seq: sequencer and shared compare/decrement unit; walks the slots
// once for match and victim search and, unless a lookup misses, once for the priority update. Depends on lpcd_pkg.
module lpcd_seq import lpcd_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int IDX_W    = $clog2(ENTRIES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      kind,
  input  logic [KEY_BITS-1:0]       key,
  output logic                      busy,
  output logic                      res_valid,
  output logic                      res_hit,
  output logic [SLOT_W-1:0]         res_slot,
  output logic                      res_replaced,
  output lpcd_mem_ctl_t             mem_ctl,
  output logic [IDX_W-1:0]          rd_addr,
  output logic [IDX_W-1:0]          key_waddr,
  output logic [KEY_BITS-1:0]       key_wdata,
  output logic [IDX_W-1:0]          prio_waddr,
  output logic signed [PRIO_W-1:0]  prio_wdata,
  input  logic [KEY_BITS-1:0]       key_rdata,
  input  logic signed [PRIO_W-1:0]  prio_rdata,
  input  logic [ENTRIES-1:0]        valid
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);
  localparam logic signed [PRIO_W-1:0] PRIO_TOP = PRIO_W'(ENTRIES);

  lpcd_state_t state_r, state_nxt;

  logic [CNT_W-1:0]         cnt_r;
  logic                     rd_vld_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic                     kind_r;
  logic [KEY_BITS-1:0]      key_r;
  logic                     found_r;
  logic [IDX_W-1:0]         found_idx_r;
  logic                     empty_r;
  logic [IDX_W-1:0]         empty_idx_r;
  logic signed [PRIO_W-1:0] low_r;
  logic [IDX_W-1:0]         low_idx_r;
  logic                     hit_r;
  logic                     repl_r;
  logic [IDX_W-1:0]         used_r;
  logic [IDX_W-1:0]         victim;
  logic                     issue;
  logic                     cnt_done;
  logic                     rd_slot_valid;
  logic [IDX_W+SLOT_W-1:0]  used_ext;

  assign cnt_done      = (cnt_r == CNT_END);
  assign issue         = ((state_r == ST_SCAN) || (state_r == ST_UPDATE)) && !cnt_done;
  assign rd_slot_valid = valid[rd_idx_r];
  assign victim        = empty_r ? empty_idx_r : low_idx_r;
  assign used_ext      = {{SLOT_W{1'b0}}, used_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (kind_r == KIND_LOOKUP && !found_r) state_nxt = ST_DONE;
        else state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cnt_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
    end
  end

  // counter, read pipeline tag, scan bookkeeping
  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r[IDX_W-1:0];
    if (state_r == ST_IDLE || state_r == ST_DECIDE) begin
      cnt_r <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
    end

    if (state_r == ST_IDLE) begin
      kind_r  <= kind;
      key_r   <= key;
      found_r <= 1'b0;
      empty_r <= 1'b0;
      low_r   <= PRIO_TOP;
      found_idx_r <= '0;
      empty_idx_r <= '0;
      low_idx_r   <= '0;
    end else if (state_r == ST_SCAN && rd_vld_r) begin
      if (rd_slot_valid) begin
        if (!found_r && key_rdata == key_r) begin
          found_r     <= 1'b1;
          found_idx_r <= rd_idx_r;
        end
        if (prio_rdata < low_r) begin
          low_r     <= prio_rdata;
          low_idx_r <= rd_idx_r;
        end
      end else if (!empty_r) begin
        empty_r     <= 1'b1;
        empty_idx_r <= rd_idx_r;
      end
    end

    if (state_r == ST_DECIDE) begin
      if (kind_r == KIND_INSERT) begin
        hit_r  <= 1'b0;
        repl_r <= !empty_r;
        used_r <= victim;
      end else begin
        hit_r  <= found_r;
        repl_r <= 1'b0;
        used_r <= found_r ? found_idx_r : '0;
      end
    end
  end

  // priority update unit
  always_comb begin
    if (rd_idx_r == used_r) begin
      prio_wdata = PRIO_TOP;
    end else if (rd_slot_valid && prio_rdata != PRIO_MIN) begin
      prio_wdata = prio_rdata - PRIO_W'(1);
    end else begin
      prio_wdata = prio_rdata;
    end
  end

  always_comb begin
    busy           = (state_r != ST_IDLE);
    res_valid      = (state_r == ST_DONE);
    mem_ctl.rd_en  = issue;
    mem_ctl.key_we = (state_r == ST_DECIDE) && (kind_r == KIND_INSERT);
    mem_ctl.prio_we = (state_r == ST_UPDATE) && rd_vld_r;
  end

  assign rd_addr      = cnt_r[IDX_W-1:0];
  assign key_waddr    = victim;
  assign key_wdata    = key_r;
  assign prio_waddr   = rd_idx_r;
  assign res_hit      = hit_r;
  assign res_replaced = repl_r;
  assign res_slot     = used_ext[SLOT_W-1:0];

endmodule

/* hw/rtl/lru_priority_cache_directory_core.sv */
`timescale 1ns / 1ps
// lru_priority_cache_directory_core: top level of the fully associative
// directory with counter-based LRU replacement. Depends on lpcd_pkg, lpcd_store, lpcd_seq.

// A transaction is taken when start is high and busy is low; busy then stays
// high until the result has been shown. The slots are walked once through the
// single read port of the key and priority memories for the match and victim
// search, then, unless a lookup misses, once more for the read-modify-write of
// the priorities. The next transaction is taken in the idle cycle after the
// result. The result sits on the out_ ports for exactly one cycle with
// out_valid high; the receiver cannot stall it. No clearing pass after reset.
module lru_priority_cache_directory_core import lpcd_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_kind,
  input  logic [IN_KEY_W-1:0] in_key,
  output logic                out_valid,
  output logic                out_hit,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_replaced
);

  localparam int IDX_W = $clog2(ENTRIES);

  lpcd_mem_ctl_t            mem_ctl;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         key_waddr;
  logic [KEY_BITS-1:0]      key_wdata;
  logic [IDX_W-1:0]         prio_waddr;
  logic signed [PRIO_W-1:0] prio_wdata;
  logic [KEY_BITS-1:0]      key_rdata;
  logic signed [PRIO_W-1:0] prio_rdata;
  logic [ENTRIES-1:0]       valid;

  lpcd_seq #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .kind         (in_kind),
    .key          (in_key[KEY_BITS-1:0]),
    .busy         (busy),
    .res_valid    (out_valid),
    .res_hit      (out_hit),
    .res_slot     (out_slot),
    .res_replaced (out_replaced),
    .mem_ctl      (mem_ctl),
    .rd_addr      (rd_addr),
    .key_waddr    (key_waddr),
    .key_wdata    (key_wdata),
    .prio_waddr   (prio_waddr),
    .prio_wdata   (prio_wdata),
    .key_rdata    (key_rdata),
    .prio_rdata   (prio_rdata),
    .valid        (valid)
  );

  lpcd_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .rd_addr    (rd_addr),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .prio_waddr (prio_waddr),
    .prio_wdata (prio_wdata),
    .key_rdata  (key_rdata),
    .prio_rdata (prio_rdata),
    .valid      (valid)
  );

endmodule
